### rtl/core/tpri_pkg.sv
// shared types and constants of the timed parameter ramp interpolator
package tpri_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MAX_LANES  = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_TARGET = 2'd2,
    OP_LOAD   = 2'd3
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BOOL   = 2'd0,
    KIND_INT    = 2'd1,
    KIND_FLOAT  = 2'd2,
    KIND_COLOUR = 2'd3
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT = 2'd1;

  localparam logic [COUNT_W-1:0] LANE_COUNT_RST = 3'd1;

endpackage

### rtl/core/tpri_if.sv
// valid/ready channel interfaces for the command and result streams
interface tpri_in_if import tpri_pkg::*; ();
  logic                      valid;
  logic                      ready;
  opcode_e                   opcode;
  logic        [TIME_W-1:0]  time_value;
  logic signed [VALUE_W-1:0] in_value_0;
  logic signed [VALUE_W-1:0] in_value_1;
  logic signed [VALUE_W-1:0] in_value_2;
  logic signed [VALUE_W-1:0] in_value_3;

  modport source (
    output valid, opcode, time_value, in_value_0, in_value_1, in_value_2, in_value_3,
    input  ready
  );
  modport sink (
    input  valid, opcode, time_value, in_value_0, in_value_1, in_value_2, in_value_3,
    output ready
  );
endinterface

interface tpri_out_if import tpri_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value_0;
  logic signed [VALUE_W-1:0] out_value_1;
  logic signed [VALUE_W-1:0] out_value_2;
  logic signed [VALUE_W-1:0] out_value_3;
  logic                      ramp_done;

  modport source (
    output valid, out_value_0, out_value_1, out_value_2, out_value_3, ramp_done,
    input  ready
  );
  modport sink (
    input  valid, out_value_0, out_value_1, out_value_2, out_value_3, ramp_done,
    output ready
  );
endinterface

### rtl/core/tpri_div.sv
// restoring divider for the fraction increment, one quotient bit per cycle
module tpri_div import tpri_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [TIME_W-1:0]        num_i,
  input  logic [TIME_W-1:0]        den_i,
  output logic                     busy_o,
  output logic [FRACTION_BITS-1:0] quot_o
);

  localparam int unsigned CW = $clog2(FRACTION_BITS + 1);

  logic                     busy_q, busy_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [TIME_W-1:0]        rem_q, rem_d;
  logic [FRACTION_BITS-1:0] quot_q, quot_d;
  logic [TIME_W:0]          rem2;
  logic                     take;

  // remainder stays below the divisor, so doubling fits one extra bit
  assign rem2 = {rem_q, 1'b0};
  assign take = rem2 >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(FRACTION_BITS);
      rem_d  = num_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = take ? TIME_W'(rem2 - {1'b0, den_i}) : rem2[TIME_W-1:0];
      quot_d = {quot_q[FRACTION_BITS-2:0], take};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

### rtl/core/tpri_lane.sv
// one interpolation lane: registered product, then rounding toward zero and offset
module tpri_lane import tpri_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [VALUE_W-1:0]       start_i,
  input  logic [VALUE_W-1:0]       target_i,
  input  logic [FRACTION_BITS:0]   frac_i,
  output logic [VALUE_W-1:0]       res_o
);

  localparam int unsigned DW = VALUE_W + 1;
  localparam int unsigned FW = FRACTION_BITS + 1;
  localparam int unsigned PW = DW + FW + 1;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [PW-1:0] bias;
  logic signed [PW-1:0] shifted;

  assign diff   = $signed({target_i[VALUE_W-1], target_i})
                - $signed({start_i[VALUE_W-1], start_i});
  assign prod_d = PW'(diff) * PW'($signed({1'b0, frac_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // negative products get one minus an lsb added so the shift truncates toward zero
  assign bias    = prod_q[PW-1] ? $signed(PW'((64'd1 << FRACTION_BITS) - 64'd1)) : '0;
  assign shifted = (prod_q + bias) >>> FRACTION_BITS;
  assign res_o   = start_i + shifted[VALUE_W-1:0];

endmodule

### rtl/core/tpri_merge.sv
// combines lane results according to value kind and active lane count
module tpri_merge import tpri_pkg::*; #(
  parameter int unsigned LANES         = 4,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  kind_e                    kind_i,
  input  logic [COUNT_W-1:0]       lane_count_i,
  input  logic [FRACTION_BITS:0]   frac_i,
  input  logic                     start_bit_i,
  input  logic                     target_bit_i,
  input  logic [VALUE_W-1:0]       lerp_i [LANES],
  output logic [VALUE_W-1:0]       res_o  [LANES]
);

  localparam logic [FRACTION_BITS:0] HALF = (FRACTION_BITS + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic [COUNT_W-1:0]     NMAX = COUNT_W'(LANES);

  logic [COUNT_W-1:0] n_act;
  logic               bool_bit;

  always_comb begin
    case (kind_i)
      KIND_BOOL:   n_act = '0;
      KIND_INT:    n_act = COUNT_W'(1);
      KIND_FLOAT: begin
        if (lane_count_i == '0) begin
          n_act = COUNT_W'(1);
        end else if (lane_count_i > NMAX) begin
          n_act = NMAX;
        end else begin
          n_act = lane_count_i;
        end
      end
      KIND_COLOUR: n_act = NMAX;
      default:     n_act = NMAX;
    endcase
  end

  assign bool_bit = (frac_i > HALF) ? target_bit_i : start_bit_i;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      res_o[i] = (COUNT_W'(i) < n_act) ? lerp_i[i] : '0;
    end
    if (kind_i == KIND_BOOL) begin
      res_o[0] = VALUE_W'(bool_bit);
    end
  end

endmodule

### rtl/core/timed_parameter_ramp_interpolator.sv
// top level of the timed parameter ramp interpolator
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    opcode, time_value, in_value_0..3
//  out_ch   out  valid/ready    out_value_0..3, ramp_done
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// a tick that runs the divider passes through the divide, add, multiply and merge states
// before the done state raises out valid; if the fraction reaches one, add goes straight to done
// other commands go straight to the done state; in ready rises with out valid
// one command is in flight at a time
// reset puts the ramp at its end (fraction one) with all lanes zero
// a stalled output holds the finished command in the done state; input stays closed
module timed_parameter_ramp_interpolator import tpri_pkg::*; #(
  parameter int unsigned LANES         = 4,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tpri_in_if.sink               in_ch,
  tpri_out_if.source            out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FW = FRACTION_BITS + 1;
  localparam logic [FW-1:0] ONE = FW'(1) << FRACTION_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_ADD   = 6'b000100,
    S_MUL   = 6'b001000,
    S_MERGE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  kind_e              kind_q;
  logic [COUNT_W-1:0] lane_count_q;

  logic [VALUE_W-1:0] start_q  [LANES];
  logic [VALUE_W-1:0] start_d  [LANES];
  logic [VALUE_W-1:0] target_q [LANES];
  logic [VALUE_W-1:0] target_d [LANES];
  logic [VALUE_W-1:0] held_q   [LANES];
  logic [VALUE_W-1:0] held_d   [LANES];
  logic [FW-1:0]      frac_q, frac_d;
  logic [TIME_W-1:0]  dur_q, dur_d;

  logic [VALUE_W-1:0] in_vals  [MAX_LANES];
  logic [VALUE_W-1:0] held_ext [MAX_LANES];
  logic [VALUE_W-1:0] lerp     [LANES];
  logic [VALUE_W-1:0] merged   [LANES];

  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_q [MAX_LANES];
  logic               out_done_q;
  logic               out_load;

  logic                     in_xfer;
  logic                     div_start;
  logic                     div_busy;
  logic [FRACTION_BITS-1:0] div_quot;
  logic [FW-1:0]            frac_room;

  assign in_vals[0] = in_ch.in_value_0;
  assign in_vals[1] = in_ch.in_value_1;
  assign in_vals[2] = in_ch.in_value_2;
  assign in_vals[3] = in_ch.in_value_3;

  for (genvar k = 0; k < MAX_LANES; k++) begin : g_ext
    if (k < LANES) begin : g_on
      assign held_ext[k] = held_q[k];
    end else begin : g_off
      assign held_ext[k] = '0;
    end
  end

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign frac_room   = ONE - frac_q;
  assign div_start   = in_xfer && (in_ch.opcode == OP_TICK) && (dur_q != '0)
                    && (in_ch.time_value < dur_q);

  tpri_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (in_ch.time_value),
    .den_i   (dur_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tpri_lane #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (state_q == S_MUL),
      .start_i  (start_q[l]),
      .target_i (target_q[l]),
      .frac_i   (frac_q),
      .res_o    (lerp[l])
    );
  end

  tpri_merge #(
    .LANES         (LANES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_merge (
    .kind_i       (kind_q),
    .lane_count_i (lane_count_q),
    .frac_i       (frac_q),
    .start_bit_i  (start_q[0][0]),
    .target_bit_i (target_q[0][0]),
    .lerp_i       (lerp),
    .res_o        (merged)
  );

  always_comb begin
    state_d  = state_q;
    start_d  = start_q;
    target_d = target_q;
    held_d   = held_q;
    frac_d   = frac_q;
    dur_d    = dur_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DONE;
          case (in_ch.opcode)
            OP_TICK: begin
              if (div_start) begin
                state_d = S_DIV;
              end else begin
                frac_d = ONE;
                held_d = target_q;
              end
            end
            OP_START: begin
              dur_d   = in_ch.time_value;
              frac_d  = '0;
              start_d = held_q;
              if (in_ch.time_value == '0) begin
                held_d = target_q;
              end
            end
            OP_TARGET: begin
              for (int i = 0; i < LANES; i++) begin
                target_d[i] = in_vals[i];
              end
            end
            OP_LOAD: begin
              for (int i = 0; i < LANES; i++) begin
                target_d[i] = in_vals[i];
                start_d[i]  = in_vals[i];
                held_d[i]   = in_vals[i];
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (FW'(div_quot) >= frac_room) begin
          frac_d  = ONE;
          held_d  = target_q;
          state_d = S_DONE;
        end else begin
          frac_d  = frac_q + FW'(div_quot);
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_MERGE;
      end
      S_MERGE: begin
        held_d  = merged;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ch.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_FLOAT;
      lane_count_q <= LANE_COUNT_RST;
      frac_q       <= ONE;
      dur_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        start_q[i]  <= '0;
        target_q[i] <= '0;
        held_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      frac_q      <= frac_d;
      dur_q       <= dur_d;
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
      target_q    <= target_d;
      held_q      <= held_d;
      if (cfg_we_i && (cfg_idx_i == CFG_VALUE_KIND)) begin
        kind_q <= kind_e'(cfg_data_i[KIND_W-1:0]);
      end
      if (cfg_we_i && (cfg_idx_i == CFG_LANE_COUNT)) begin
        lane_count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= held_ext;
      out_done_q <= (frac_q == ONE);
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.out_value_0 = out_q[0];
  assign out_ch.out_value_1 = out_q[1];
  assign out_ch.out_value_2 = out_q[2];
  assign out_ch.out_value_3 = out_q[3];
  assign out_ch.ramp_done   = out_done_q;

`ifndef SYNTH
  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= ONE)
    else $error("ramp fraction above one");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_DIV))
    else $error("divider busy outside the divide state");

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("command transfer did not start processing");

  a_add_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> $past(state_q == S_DIV))
    else $error("fraction update without a finished division");
`endif

endmodule
